// ===== rtl/console_line_editor_unit_defines.svh =====
// Assertion macros for the console line editor
`ifndef CONSOLE_LINE_EDITOR_UNIT_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset
`define CLE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cle_pkg.sv =====
// Shared types, key codes and control/status bundles for the console line editor
package cle_pkg;

   localparam int LINE_BUFFER_BYTES_DEF = 64;

   localparam logic [7:0] KEY_NUL   = 8'h00;
   localparam logic [7:0] KEY_BREAK = 8'h03;
   localparam logic [7:0] KEY_BS    = 8'h08;
   localparam logic [7:0] KEY_LF    = 8'h0A;
   localparam logic [7:0] KEY_CR    = 8'h0D;
   localparam logic [7:0] KEY_KILL  = 8'h15;
   localparam logic [7:0] KEY_WORD  = 8'h17;
   localparam logic [7:0] KEY_SPACE = 8'h20;
   localparam logic [7:0] KEY_DEL   = 8'h7F;

   typedef enum logic [2:0] {
      EV_STORED    = 3'd0,
      EV_DROPPED   = 3'd1,
      EV_NUL       = 3'd2,
      EV_ERASED    = 3'd3,
      EV_CLEARED   = 3'd4,
      EV_DISCARDED = 3'd5,
      EV_LINE_BYTE = 3'd6,
      EV_EMPTY     = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      CLS_PLAIN = 3'd0,
      CLS_ENTER = 3'd1,
      CLS_NUL   = 3'd2,
      CLS_BREAK = 3'd3,
      CLS_KILL  = 3'd4,
      CLS_WORD  = 3'd5,
      CLS_ERASE = 3'd6
   } byte_class_type;

   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_INC   = 2'd1,
      CNT_DEC   = 2'd2,
      CNT_CLEAR = 2'd3
   } cnt_op_type;

   typedef struct packed {
      logic       capture;       // latch the request byte
      cnt_op_type cnt_op;
      logic       mem_wr;        // store the byte at the fill count
      logic       rd_issue;      // read the line store
      logic       rd_sel_idx;    // read at emit index, else at count-1
      logic       idx_clear;
      logic       idx_inc;
      logic       out_load;      // write the response register
      event_type  out_event;
   } cmd_type;

   typedef struct packed {
      logic           slot_free;
      byte_class_type byte_class;
      logic           count_zero;
      logic           count_full;
      logic           rd_is_space;
      logic           idx_last;
   } stat_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      case (b)
         KEY_CR, KEY_LF:  c = CLS_ENTER;
         KEY_NUL:         c = CLS_NUL;
         KEY_BREAK:       c = CLS_BREAK;
         KEY_KILL:        c = CLS_KILL;
         KEY_WORD:        c = CLS_WORD;
         KEY_BS, KEY_DEL: c = CLS_ERASE;
         default:         c = CLS_PLAIN;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/cle_datapath.sv =====
// Line store, fill count, emit index and response register of the line editor
module cle_datapath
   import cle_pkg::*;
#(
   parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_rx_byte,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output event_type  rsp_event_res,
   output logic [7:0] rsp_char_value,
   output logic [5:0] rsp_line_length,
   output logic       rsp_last
);

   localparam int AW = $clog2(LINE_BUFFER_BYTES);
   localparam logic [AW-1:0] FULL_COUNT = AW'(LINE_BUFFER_BYTES - 2);

   logic [7:0]    line_mem [LINE_BUFFER_BYTES];
   logic [7:0]    byte_ff;
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] count_m1;
   logic [AW-1:0] rd_addr;
   logic          rsp_valid_ff, rsp_valid_in;
   event_type     event_ff;
   logic [7:0]    char_ff;
   logic [5:0]    length_ff;
   logic          last_ff;
   logic          is_line_byte;

   assign count_m1     = count_ff - 1'b1;
   assign rd_addr      = cmd.rd_sel_idx ? idx_ff : count_m1;
   assign is_line_byte = (cmd.out_event == EV_LINE_BYTE);

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + 1'b1;
         CNT_DEC:   count_in = (count_ff == '0) ? count_ff : count_m1;
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.capture) begin
         byte_ff <= req_rx_byte;
      end
      if (cmd.out_load) begin
         event_ff  <= cmd.out_event;
         char_ff   <= is_line_byte ? rd_data_ff : 8'h00;
         // line bytes report the emitted length, the rest the count after the edit
         length_ff <= 6'(is_line_byte ? count_ff : count_in);
         last_ff   <= is_line_byte ? stat.idx_last : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         line_mem[count_ff] <= byte_ff;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign stat.slot_free   = !rsp_valid_ff || rsp_ready;
   assign stat.byte_class  = classify(byte_ff);
   assign stat.count_zero  = (count_ff == '0);
   assign stat.count_full  = (count_ff >= FULL_COUNT);
   assign stat.rd_is_space = (rd_data_ff == KEY_SPACE);
   assign stat.idx_last    = (idx_ff == count_m1);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = event_ff;
   assign rsp_char_value  = char_ff;
   assign rsp_line_length = length_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== rtl/cle_controller.sv =====
// Sequencing state machine of the line editor
module cle_controller
   import cle_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_WREAD  = 7'b0000100,
      S_WTEST  = 7'b0001000,
      S_WDONE  = 7'b0010000,
      S_EREAD  = 7'b0100000,
      S_ESEND  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '{capture: 1'b0, cnt_op: CNT_HOLD, mem_wr: 1'b0, rd_issue: 1'b0,
                    rd_sel_idx: 1'b0, idx_clear: 1'b0, idx_inc: 1'b0,
                    out_load: 1'b0, out_event: EV_STORED};
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.byte_class)
               CLS_ENTER: begin
                  if (!stat.count_zero) begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_EREAD;
                  end else if (stat.slot_free) begin
                     cmd.out_load  = 1'b1;
                     cmd.out_event = EV_EMPTY;
                     cmd.cnt_op    = CNT_CLEAR;
                     state_in      = S_IDLE;
                  end
               end
               CLS_WORD: begin
                  // drop the last byte, then walk back to the previous space
                  cmd.cnt_op = CNT_DEC;
                  state_in   = S_WREAD;
               end
               default: begin
                  if (stat.slot_free) begin
                     cmd.out_load = 1'b1;
                     state_in     = S_IDLE;
                     case (stat.byte_class)
                        CLS_NUL: cmd.out_event = EV_NUL;
                        CLS_BREAK: begin
                           cmd.out_event = EV_DISCARDED;
                           cmd.cnt_op    = CNT_CLEAR;
                        end
                        CLS_KILL: begin
                           cmd.out_event = EV_CLEARED;
                           cmd.cnt_op    = CNT_CLEAR;
                        end
                        CLS_ERASE: begin
                           cmd.out_event = EV_ERASED;
                           cmd.cnt_op    = CNT_DEC;
                        end
                        default: begin
                           if (stat.count_full) begin
                              cmd.out_event = EV_DROPPED;
                           end else begin
                              cmd.out_event = EV_STORED;
                              cmd.mem_wr    = 1'b1;
                              cmd.cnt_op    = CNT_INC;
                           end
                        end
                     endcase
                  end
               end
            endcase
         end
         S_WREAD: begin
            if (stat.count_zero) begin
               state_in = S_WDONE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_WTEST;
            end
         end
         S_WTEST: begin
            if (stat.rd_is_space) begin
               state_in = S_WDONE;
            end else begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_WREAD;
            end
         end
         S_WDONE: begin
            if (stat.slot_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_event = EV_ERASED;
               state_in      = S_IDLE;
            end
         end
         S_EREAD: begin
            cmd.rd_issue   = 1'b1;
            cmd.rd_sel_idx = 1'b1;
            state_in       = S_ESEND;
         end
         S_ESEND: begin
            if (stat.slot_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_event = EV_LINE_BYTE;
               if (stat.idx_last) begin
                  cmd.cnt_op = CNT_CLEAR;
                  state_in   = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_EREAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/console_line_editor_unit.sv =====
// Console line editor: edits received terminal bytes into a line and emits it on enter.
// One request is in flight at a time. An ordinary byte, NUL, backspace/DEL, Ctrl-U or Ctrl-C
// is accepted, then decoded once the response register is free. Ctrl-W walks back through
// the line until it reaches the start of the line or a space; CR/LF emits the held bytes
// one by one. Both walks are paced by the single read port of the line store and its
// registered read data. A new request is taken while a finished response still waits in
// the output register. The line store needs no clearing pass after reset: only bytes below
// the fill count are ever read.
`include "console_line_editor_unit_defines.svh"

module console_line_editor_unit
   import cle_pkg::*;
#(
   parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_char_value,
   output logic [5:0] rsp_line_length,
   output logic       rsp_last
);

   cmd_type   cmd;
   stat_type  stat;
   event_type rsp_event;

   cle_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cle_datapath #(
      .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_event_res   (rsp_event),
      .rsp_char_value  (rsp_char_value),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

   assign rsp_event_res = rsp_event;

   `CLE_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready, "second request taken while busy")
   `CLE_ASSERT_NOW(a_len_bound, rsp_valid, rsp_line_length <= 6'(LINE_BUFFER_BYTES - 2), "line length beyond capacity")
   `CLE_ASSERT_NOW(a_char_zero, rsp_valid && rsp_event != EV_LINE_BYTE, rsp_char_value == 8'h00, "char set on non-line event")
   `CLE_ASSERT_NOW(a_empty_len, rsp_valid && rsp_event == EV_EMPTY, rsp_line_length == 6'd0 && rsp_last, "empty line with length")

endmodule

// ===== sim/console_line_editor_unit_tb.sv =====
// Self-checking testbench for the console line editor: predicts every response and compares.
import cle_pkg::*;

typedef struct packed {
   event_type  ev;
   logic [7:0] ch;
   logic [5:0] len;
   logic       fin;
} line_event_type;

class line_editor_scoreboard;
   localparam int LINE_MAX = LINE_BUFFER_BYTES_DEF - 2;

   logic [7:0]  held_bytes [LINE_BUFFER_BYTES_DEF];
   int unsigned fill;
   line_event_type awaited_events [$];
   int          errors;

   function new();
      fill = 0;
      errors = 0;
   endfunction

   function int pending();
      return awaited_events.size();
   endfunction

   task report(input string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
   endtask

   function void push_event(input event_type ev, input logic [7:0] ch,
                            input int unsigned len, input logic fin);
      line_event_type e;
      e.ev  = ev;
      e.ch  = ch;
      e.len = len[5:0];
      e.fin = fin;
      awaited_events.push_back(e);
   endfunction

   // Apply one accepted request to the line and queue the responses it causes.
   function void note_request(input logic [7:0] b);
      int unsigned n;
      case (b)
         KEY_CR, KEY_LF: begin
            n = fill;
            if (n == 0) begin
               push_event(EV_EMPTY, 8'h00, 0, 1'b1);
            end else begin
               for (int unsigned i = 0; i < n; i++)
                  push_event(EV_LINE_BYTE, held_bytes[i], n, i + 1 == n);
            end
            fill = 0;
         end
         KEY_NUL: push_event(EV_NUL, 8'h00, fill, 1'b1);
         KEY_BREAK: begin
            fill = 0;
            push_event(EV_DISCARDED, 8'h00, 0, 1'b1);
         end
         KEY_KILL: begin
            fill = 0;
            push_event(EV_CLEARED, 8'h00, 0, 1'b1);
         end
         KEY_WORD: begin
            // drop the last byte, then walk back to the space before the word
            if (fill > 0) fill--;
            while (fill > 0 && held_bytes[fill - 1] != KEY_SPACE) fill--;
            push_event(EV_ERASED, 8'h00, fill, 1'b1);
         end
         KEY_BS, KEY_DEL: begin
            if (fill > 0) fill--;
            push_event(EV_ERASED, 8'h00, fill, 1'b1);
         end
         default: begin
            if (fill < LINE_MAX) begin
               held_bytes[fill] = b;
               fill++;
               push_event(EV_STORED, 8'h00, fill, 1'b1);
            end else begin
               push_event(EV_DROPPED, 8'h00, fill, 1'b1);
            end
         end
      endcase
   endfunction

   task check_response(input logic [2:0] ev, input logic [7:0] ch,
                       input logic [5:0] len, input logic fin);
      line_event_type e;
      if (awaited_events.size() == 0) begin
         report($sformatf("response ev=%0d ch=%02h len=%0d last=%0b with nothing pending",
                          ev, ch, len, fin));
      end else begin
         e = awaited_events.pop_front();
         if (ev !== e.ev)
            report($sformatf("event_res got %0d want %0d", ev, e.ev));
         if (ch !== e.ch)
            report($sformatf("char_value got %02h want %02h", ch, e.ch));
         if (len !== e.len)
            report($sformatf("line_length got %0d want %0d", len, e.len));
         if (fin !== e.fin)
            report($sformatf("last got %0b want %0b", fin, e.fin));
      end
   endtask
endclass

module console_line_editor_unit_tb;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int REQUEST_GOAL = 310;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_event_res;
   logic [7:0] rsp_char_value;
   logic [5:0] rsp_line_length;
   logic       rsp_last;

   line_editor_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int requests_sent;
   int cycles;

   console_line_editor_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_char_value (rsp_char_value),
      .rsp_line_length(rsp_line_length),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_event_res, rsp_char_value, rsp_line_length, rsp_last);
   end

   // Hold the byte until the handshake, then note it; valid stays up for a back-to-back request.
   task send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_request(b);
      requests_sent++;
   endtask

   function logic [7:0] text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 20) return KEY_SPACE;
      if (r < 30) return 8'($urandom_range(8'h80, 8'hFF));
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   // Type a line of random text with occasional edits and noise, then end it.
   task type_line(input int len);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         if (r < 6) send_byte($urandom_range(1) ? KEY_BS : KEY_DEL);
         else if (r < 9) send_byte(KEY_WORD);
         else if (r < 12) send_byte(8'($urandom_range(255)));
         else send_byte(text_byte());
      end
      r = $urandom_range(99);
      if (r < 45) send_byte(KEY_CR);
      else if (r < 80) send_byte(KEY_LF);
      else if (r < 90) send_byte(KEY_KILL);
      else send_byte(KEY_BREAK);
   endtask

   task type_random_lines(input int goal);
      int r;
      while (requests_sent < goal) begin
         r = $urandom_range(99);
         if (r < 15) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
         end else if (r < 19) begin
            type_line($urandom_range(55, 75));
         end else if (r < 35) begin
            type_line($urandom_range(13, 40));
         end else begin
            type_line($urandom_range(0, 12));
         end
      end
   endtask

   initial begin
      logic [7:0] opening [$];
      sb = new();
      cycles <= 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'h00;
      rsp_ready <= 1'b0;
      send_idle_pct = 37;
      recv_stall_pct = 87;
      requests_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty-line edits, field extremes, word erase to a space and to the start
      opening = '{KEY_CR, KEY_LF, KEY_BS, KEY_DEL, KEY_WORD, KEY_NUL, 8'hFF, 8'h01, 8'h61,
                  KEY_SPACE, 8'h62, 8'h63, KEY_WORD, KEY_NUL, KEY_BS, KEY_DEL, 8'h80, 8'h09,
                  KEY_LF, 8'h78, 8'h79, KEY_WORD, 8'h7A, KEY_KILL, 8'h77, KEY_BREAK, KEY_CR};
      foreach (opening[i]) send_byte(opening[i]);

      // overflow the line once, then random traffic
      type_line(68);
      type_random_lines(REQUEST_GOAL / 3);
      send_idle_pct = 87;
      recv_stall_pct = 37;
      type_random_lines(2 * REQUEST_GOAL / 3);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      type_random_lines(REQUEST_GOAL);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/cle_pkg.sv
rtl/cle_datapath.sv
rtl/cle_controller.sv
rtl/console_line_editor_unit.sv
sim/console_line_editor_unit_tb.sv
